// ----- sv/shaped_morse_keyer_defines.svh -----
// Assertion macros for the keyer checker
`ifndef SHAPED_MORSE_KEYER_DEFINES_SVH
`define SHAPED_MORSE_KEYER_DEFINES_SVH

// same-cycle implication, off during reset
`define SKP_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SKP_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- sv/skp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skp_pkg
// Shared types, constants and lookup functions of the shaped keyer.
// ---------------------------------------------------------------------------
package skp_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int ADDR_BITS    = $clog2(MAX_SEGMENTS);
    localparam int LENGTH_BITS  = 24;
    localparam int SAMPLE_BITS  = 16;
    localparam int ROUND_SHIFT  = 31 - SAMPLE_BITS;
    localparam int DIV_STEPS    = 7;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    localparam logic [7:0] CFG_AMPLITUDE     = 8'd0;
    localparam logic [7:0] CFG_PHASE_STEP    = 8'd1;
    localparam logic [7:0] CFG_RAMP_LENGTH   = 8'd2;
    localparam logic [7:0] CFG_SEGMENT_COUNT = 8'd3;

    localparam logic [14:0] QUARTER_SINE [0:64] = '{
        15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
        15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
        15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
        15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
        15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
        15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
        15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
        15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
        15'd32767
    };

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [7:0]             index;
        logic                   key_on;
        logic [LENGTH_BITS-1:0] length;
    } seg_word_t;

    typedef struct packed {
        logic [15:0] amplitude;
        logic [31:0] phase_step;
        logic [15:0] ramp_length;
        logic [8:0]  segment_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DIV,
        ST_ENV,
        ST_SCALE,
        ST_MULI,
        ST_MULQ,
        ST_OUT
    } back_state_t;

    function automatic logic signed [15:0] sine_at(input logic [7:0] idx);
        logic [5:0]  k;
        logic [6:0]  kr;
        logic [15:0] v;
        k  = idx[5:0];
        kr = 7'd64 - {1'b0, k};
        case (idx[7:6])
            2'd0:    v = {1'b0, QUARTER_SINE[k]};
            2'd1:    v = {1'b0, QUARTER_SINE[kr]};
            2'd2:    v = -{1'b0, QUARTER_SINE[k]};
            default: v = -{1'b0, QUARTER_SINE[kr]};
        endcase
        return $signed(v);
    endfunction

    function automatic logic signed [15:0] cosine_at(input logic [7:0] idx);
        return sine_at(idx + 8'd64);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [32:0] p);
        logic [32:0] mag;
        logic [32:0] mr;
        logic [32:0] maxv;
        logic [SAMPLE_BITS-1:0] res;
        maxv = 33'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
        mag  = p[32] ? 33'(-p) : 33'(p);
        mr   = (mag + (33'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (p[32]) begin
            if (mr > maxv + 33'd1) res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            else res = SAMPLE_BITS'(-mr);
        end else begin
            if (mr > maxv) res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            else res = SAMPLE_BITS'(mr);
        end
        return $signed(res);
    endfunction

endpackage

// ----- sv/skp_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skp_front
// Accept input words, tag tick or load, and queue them for the back end.
// ---------------------------------------------------------------------------
module skp_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [7:0]                         s_segment_index,
    input  logic                               s_segment_key_on,
    input  logic [skp_pkg::LENGTH_BITS-1:0]    s_segment_length,
    output logic                               q_valid,
    input  logic                               q_ready,
    output skp_pkg::seg_word_t                 q_word
);

    skp_pkg::seg_word_t slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    skp_pkg::seg_word_t in_word;

    always_comb begin
        in_word.op     = s_operation ? skp_pkg::OP_LOAD : skp_pkg::OP_TICK;
        in_word.index  = s_segment_index;
        in_word.key_on = s_segment_key_on;
        in_word.length = s_segment_length;
    end

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_word  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

// ----- sv/skp_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skp_back
// Hold the segment table, run the schedule, shape and scale each sample.
// ---------------------------------------------------------------------------
module skp_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  skp_pkg::cfg_t                          cfg,
    input  logic                                   q_valid,
    output logic                                   q_ready,
    input  skp_pkg::seg_word_t                     q_word,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [skp_pkg::SAMPLE_BITS-1:0] m_i_sample,
    output logic signed [skp_pkg::SAMPLE_BITS-1:0] m_q_sample,
    output logic                                   m_keyed
);

    localparam int LB = skp_pkg::LENGTH_BITS;
    localparam int AB = skp_pkg::ADDR_BITS;
    localparam int SB = skp_pkg::SAMPLE_BITS;

    logic [LB:0] seg_mem [0:skp_pkg::MAX_SEGMENTS-1];
    logic [LB:0] rd_data_reg;

    skp_pkg::back_state_t state_reg, state_next;

    logic [AB-1:0] ptr_reg, ptr_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic [31:0]   phase_reg, phase_next;
    logic [AB-1:0] rd_addr;
    logic          mem_wr, mem_rd;

    logic [7:0]    tidx_reg, tidx_next;
    logic          key_reg, key_next;
    logic [15:0]   r_reg, r_next;
    logic [16:0]   rem_reg, rem_next;
    logic [6:0]    quo_reg, quo_next;
    logic [skp_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [16:0]   env_reg, env_next;
    logic [15:0]   scale_reg, scale_next;
    logic signed [32:0]   prod_reg, prod_next;
    logic signed [SB-1:0] isamp_reg, isamp_next;

    logic          out_valid_reg, out_valid_next;
    logic signed [SB-1:0] out_i_reg, out_i_next;
    logic signed [SB-1:0] out_q_reg, out_q_next;
    logic          out_key_reg, out_key_next;

    logic [8:0]    count_eff;
    logic          ptr_over;
    logic          rd_key;
    logic [LB-1:0] rd_len;
    logic [LB-2:0] half_len;
    logic [15:0]   r_val;
    logic [LB:0]   pos_inc;
    logic [16:0]   rem_sh;
    logic signed [15:0] cos_q;
    logic signed [17:0] env_diff;
    logic [32:0]   amp_prod;
    logic [8:0]    ptr_inc;

    assign m_valid    = out_valid_reg;
    assign m_i_sample = out_i_reg;
    assign m_q_sample = out_q_reg;
    assign m_keyed    = out_key_reg;

    always_comb begin
        if (cfg.segment_count == 9'd0) count_eff = 9'd1;
        else if (cfg.segment_count > 9'(skp_pkg::MAX_SEGMENTS)) count_eff = 9'(skp_pkg::MAX_SEGMENTS);
        else count_eff = cfg.segment_count;
        ptr_over = ({1'b0, ptr_reg} >= count_eff);
        rd_addr  = ptr_over ? '0 : ptr_reg;
        rd_key   = rd_data_reg[LB];
        rd_len   = rd_data_reg[LB-1:0];
        half_len = rd_len[LB-1:1];
        r_val    = ({{(LB-17){1'b0}}, cfg.ramp_length} < half_len) ? cfg.ramp_length
                                                                   : 16'(half_len);
        pos_inc  = {1'b0, pos_reg} + {{LB{1'b0}}, 1'b1};
        ptr_inc  = {1'b0, ptr_reg} + 9'd1;
        rem_sh   = {rem_reg[15:0], 1'b0};
        cos_q    = skp_pkg::cosine_at({1'b0, quo_reg});
        env_diff = 18'sd32768 - {{2{cos_q[15]}}, cos_q};
        amp_prod = {17'd0, cfg.amplitude} * {16'd0, env_reg};
    end

    always_comb begin
        state_next     = state_reg;
        q_ready        = 1'b0;
        mem_wr         = 1'b0;
        mem_rd         = 1'b0;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        tidx_next      = tidx_reg;
        key_next       = key_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        env_next       = env_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        isamp_next     = isamp_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_i_next     = out_i_reg;
        out_q_next     = out_q_reg;
        out_key_next   = out_key_reg;
        case (state_reg)
            skp_pkg::ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_word.op == skp_pkg::OP_LOAD) begin
                        mem_wr = ({1'b0, q_word.index} < 9'(skp_pkg::MAX_SEGMENTS));
                    end else begin
                        mem_rd = 1'b1;
                        if (ptr_over) begin
                            ptr_next = '0;
                            pos_next = '0;
                        end
                        state_next = skp_pkg::ST_LOOK;
                    end
                end
            end
            skp_pkg::ST_LOOK: begin
                tidx_next  = phase_reg[31:24];
                phase_next = phase_reg + cfg.phase_step;
                key_next   = rd_key;
                r_next     = r_val;
                quo_next   = '0;
                cnt_next   = '0;
                if (!rd_key) begin
                    env_next   = '0;
                    state_next = skp_pkg::ST_SCALE;
                end else if (r_val == 16'd0) begin
                    env_next   = 17'd32768;
                    state_next = skp_pkg::ST_SCALE;
                end else if (pos_reg < {{(LB-16){1'b0}}, r_val}) begin
                    rem_next   = {1'b0, pos_reg[15:0]};
                    state_next = skp_pkg::ST_DIV;
                end else if (pos_reg >= rd_len - {{(LB-16){1'b0}}, r_val}) begin
                    if (pos_inc >= {1'b0, rd_len}) rem_next = '0;
                    else rem_next = {1'b0, 16'(rd_len - pos_reg - {{(LB-1){1'b0}}, 1'b1})};
                    state_next = skp_pkg::ST_DIV;
                end else begin
                    env_next   = 17'd32768;
                    state_next = skp_pkg::ST_SCALE;
                end
                if (pos_inc >= {1'b0, rd_len}) begin
                    pos_next = '0;
                    ptr_next = (ptr_inc >= count_eff) ? '0 : AB'(ptr_inc);
                end else begin
                    pos_next = pos_inc[LB-1:0];
                end
            end
            skp_pkg::ST_DIV: begin
                if (rem_sh >= {1'b0, r_reg}) begin
                    rem_next = rem_sh - {1'b0, r_reg};
                    quo_next = {quo_reg[5:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[5:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == skp_pkg::DIV_CNT_BITS'(skp_pkg::DIV_STEPS - 1)) begin
                    state_next = skp_pkg::ST_ENV;
                end
            end
            skp_pkg::ST_ENV: begin
                env_next   = {1'b0, env_diff[16:1]};
                state_next = skp_pkg::ST_SCALE;
            end
            skp_pkg::ST_SCALE: begin
                scale_next = amp_prod[30:15];
                state_next = skp_pkg::ST_MULI;
            end
            skp_pkg::ST_MULI: begin
                prod_next  = $signed({1'b0, scale_reg}) * skp_pkg::cosine_at(tidx_reg);
                state_next = skp_pkg::ST_MULQ;
            end
            skp_pkg::ST_MULQ: begin
                isamp_next = skp_pkg::round_sat(prod_reg);
                prod_next  = $signed({1'b0, scale_reg}) * skp_pkg::sine_at(tidx_reg);
                state_next = skp_pkg::ST_OUT;
            end
            skp_pkg::ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_i_next     = isamp_reg;
                    out_q_next     = skp_pkg::round_sat(prod_reg);
                    out_key_next   = key_reg;
                    state_next     = skp_pkg::ST_IDLE;
                end
            end
            default: state_next = skp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= skp_pkg::ST_IDLE;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tidx_reg    <= tidx_next;
        key_reg     <= key_next;
        r_reg       <= r_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        env_reg     <= env_next;
        scale_reg   <= scale_next;
        prod_reg    <= prod_next;
        isamp_reg   <= isamp_next;
        out_i_reg   <= out_i_next;
        out_q_reg   <= out_q_next;
        out_key_reg <= out_key_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            seg_mem[q_word.index[AB-1:0]] <= {q_word.key_on, q_word.length};
        end
        if (mem_rd) begin
            rd_data_reg <= seg_mem[rd_addr];
        end
    end

endmodule

// ----- sv/shaped_morse_keyer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shaped_morse_keyer
// Keyed CW beacon with raised-cosine envelope and complex NCO output.
// ---------------------------------------------------------------------------
// Input channel (s_*): operation 1 loads a segment table entry and gives no
// word on the output; operation 0 is a tick that gives one I/Q sample word.
// Config channel (cfg_*): index 0 amplitude, 1 phase_step, 2 ramp_length,
// 3 segment_count; always ready, write only while the block is idle.
// A two-word queue parts the input side from the sample engine.
// A load is a table write in the idle state. A tick on a ramp edge runs
// queue pop with table read, segment decode, a 7-step restoring divider for
// the ramp index, envelope, amplitude scale, the I and Q multiplier steps
// and the output load. Flat, unramped and key-off samples skip the divider
// and envelope. The engine takes the next queue word only once it is back
// in idle, after the last tick has been loaded into the output register.
// Reset clears the queue, pointer, position, phase and the config registers
// (segment_count to 1); the segment table is undefined until loaded.
// When m_ready is low the sample holds in the output register; the engine
// finishes the next tick and then waits, and the queue fills and drops s_ready.
// ---------------------------------------------------------------------------
module shaped_morse_keyer (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_operation,
    input  logic [7:0]                             s_segment_index,
    input  logic                                   s_segment_key_on,
    input  logic [skp_pkg::LENGTH_BITS-1:0]        s_segment_length,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [skp_pkg::SAMPLE_BITS-1:0] m_i_sample,
    output logic signed [skp_pkg::SAMPLE_BITS-1:0] m_q_sample,
    output logic                                   m_keyed,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [7:0]                             cfg_index,
    input  logic [31:0]                            cfg_data
);

    skp_pkg::cfg_t      cfg_reg, cfg_next;
    logic               q_valid, q_ready;
    skp_pkg::seg_word_t q_word;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                skp_pkg::CFG_AMPLITUDE:     cfg_next.amplitude     = cfg_data[15:0];
                skp_pkg::CFG_PHASE_STEP:    cfg_next.phase_step    = cfg_data;
                skp_pkg::CFG_RAMP_LENGTH:   cfg_next.ramp_length   = cfg_data[15:0];
                skp_pkg::CFG_SEGMENT_COUNT: cfg_next.segment_count = cfg_data[8:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.amplitude     <= '0;
            cfg_reg.phase_step    <= '0;
            cfg_reg.ramp_length   <= '0;
            cfg_reg.segment_count <= 9'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    skp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_segment_index  (s_segment_index),
        .s_segment_key_on (s_segment_key_on),
        .s_segment_length (s_segment_length),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_word           (q_word)
    );

    skp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_word     (q_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_i_sample (m_i_sample),
        .m_q_sample (m_q_sample),
        .m_keyed    (m_keyed)
    );

endmodule

// ----- sv/skp_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skp_checker
// Port-level checks of the keyer, bound to the top level.
// ---------------------------------------------------------------------------
`include "shaped_morse_keyer_defines.svh"

module skp_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [skp_pkg::SAMPLE_BITS-1:0] m_i_sample,
    input logic signed [skp_pkg::SAMPLE_BITS-1:0] m_q_sample,
    input logic                                   m_keyed,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready
);

    `SKP_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid, "output word dropped while stalled")
    `SKP_ASSERT_IMP(a_silent_off, m_valid && !m_keyed, m_i_sample == '0 && m_q_sample == '0, "key-off sample not silent")
    `SKP_ASSERT_IMP(a_reset_empty, !$past(aresetn), !m_valid, "output valid right after reset")
    `SKP_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind shaped_morse_keyer skp_checker u_skp_checker (.*);
